### hw/rtl/lcf_pkg.sv
package lcf_pkg;

  localparam int TAPS_DEF   = 32;
  localparam int RESULT_CAP = 32;
  localparam int CNT_W      = 6;
  localparam int SAMPLE_W   = 16;
  localparam int INDEX_W    = 5;
  localparam int PROD_W     = 32;
  localparam int ACC_W      = 40;
  localparam int FRAC_W     = 15;

  localparam logic [CNT_W-1:0] TAP_COUNT_RST = CNT_W'(32);

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef struct packed {
    logic             coef_we;
    logic             shift_we;
    logic             shift_zero;
    logic             clr_we;
    logic             rd_en;
    logic [CNT_W-1:0] rd_idx;
    logic             acc_clr;
    logic             out_ld;
    logic             out_last;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] taps;
    logic             busy;
  } sts_t;

endpackage

### hw/rtl/lcf_ifs.sv
interface lcf_in_if
  import lcf_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [INDEX_W-1:0]         tap_index;
  logic signed [SAMPLE_W-1:0] value;
  logic                       final_sample;

  modport source (output valid, output opcode, output tap_index, output value,
                  output final_sample, input ready);
  modport sink (input valid, input opcode, input tap_index, input value,
                input final_sample, output ready);
endinterface

interface lcf_out_if
  import lcf_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       clipped;
  logic                       block_end;

  modport source (output valid, output out_sample, output clipped, output block_end,
                  input ready);
  modport sink (input valid, input out_sample, input clipped, input block_end,
                output ready);
endinterface

interface lcf_cfg_if
  import lcf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/lcf_ctrl.sv
module lcf_ctrl
  import lcf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_opcode,
  input  logic in_final,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MAC   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] tail_r, tail_nxt;
  logic             fin_r, fin_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    tail_nxt  = tail_r;
    fin_nxt   = fin_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_LOAD) begin
            cmd.coef_we = 1'b1;
          end else begin
            cmd.shift_we = 1'b1;
            fin_nxt      = in_final;
            tail_nxt     = in_final ? sts.taps - 1'b1 : '0;
            k_nxt        = '0;
            state_nxt    = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_idx  = k_r;
        cmd.acc_clr = (k_r == '0);
        k_nxt       = k_r + 1'b1;
        if (k_r == sts.taps - 1'b1) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.out_ld   = 1'b1;
          cmd.out_last = fin_r && (tail_r == '0);
          if (tail_r != '0) begin
            cmd.shift_we   = 1'b1;
            cmd.shift_zero = 1'b1;
            tail_nxt       = tail_r - 1'b1;
            k_nxt          = '0;
            state_nxt      = ST_MAC;
          end else begin
            cmd.clr_we = fin_r;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.out_ld ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      tail_r      <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      tail_r      <= tail_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hw/rtl/lcf_datapath.sv
module lcf_datapath
  import lcf_pkg::*;
#(
  parameter int TAPS = TAPS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cmd_t                       cmd,
  output sts_t                       sts,
  input  logic                       cfg_we,
  input  logic [CNT_W-1:0]           cfg_data,
  input  logic [INDEX_W-1:0]         in_tap_index,
  input  logic signed [SAMPLE_W-1:0] in_value,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic                       out_clipped,
  output logic                       out_block_end
);

  localparam int AW   = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int LMAX = (TAPS < RESULT_CAP) ? TAPS : RESULT_CAP;

  logic [CNT_W-1:0] tap_count_r;
  logic [CNT_W-1:0] taps;

  logic signed [SAMPLE_W-1:0] coef_mem [TAPS];
  logic signed [SAMPLE_W-1:0] dl_mem [TAPS];
  logic [TAPS-1:0]            coef_vld_r;
  logic [TAPS-1:0]            dl_vld_r;

  logic [AW-1:0]              hp_r, hp_nxt;
  logic [AW-1:0]              hp_dec;
  logic [AW:0]                rd_sum;
  logic [AW-1:0]              rd_phys;
  logic [AW:0]                clr_sum;
  logic [AW-1:0]              clr_phys;
  logic [CNT_W-1:0]           taps_m1;
  logic [AW-1:0]              coef_rd_addr;
  logic [INDEX_W+1:0]         ti_ext;
  logic                       ti_ok;
  logic                       dl_we;
  logic [AW-1:0]              dl_wr_addr;
  logic signed [SAMPLE_W-1:0] dl_wr_data;

  logic signed [SAMPLE_W-1:0] coef_rd_r, dl_rd_r;
  logic                       coef_rv_r, dl_rv_r;
  logic                       rd_vld_r, prod_vld_r;
  logic signed [SAMPLE_W-1:0] coef_op, dl_op;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [ACC_W-1:0]    rnd;
  logic signed [ACC_W-FRAC_W-1:0] y;
  logic signed [SAMPLE_W-1:0] sat_val;
  logic                       sat_flag;

  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_clipped_r, out_block_end_r;

  always_comb begin
    if (tap_count_r == '0) begin
      taps = CNT_W'(1);
    end else if (tap_count_r > CNT_W'(LMAX)) begin
      taps = CNT_W'(LMAX);
    end else begin
      taps = tap_count_r;
    end
  end

  assign sts.taps = taps;
  assign sts.busy = rd_vld_r || prod_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAP_COUNT_RST;
    end else if (cfg_we) begin
      tap_count_r <= cfg_data;
    end
  end

  assign hp_dec   = (hp_r == '0) ? AW'(TAPS - 1) : hp_r - 1'b1;
  assign hp_nxt   = cmd.shift_we ? hp_dec : hp_r;
  assign rd_sum   = {1'b0, hp_r} + {1'b0, cmd.rd_idx[AW-1:0]};
  assign rd_phys  = (rd_sum >= (AW+1)'(TAPS)) ? AW'(rd_sum - (AW+1)'(TAPS)) : rd_sum[AW-1:0];
  assign taps_m1  = taps - 1'b1;
  assign clr_sum  = {1'b0, hp_r} + {1'b0, taps_m1[AW-1:0]};
  assign clr_phys = (clr_sum >= (AW+1)'(TAPS)) ? AW'(clr_sum - (AW+1)'(TAPS))
                                               : clr_sum[AW-1:0];
  assign coef_rd_addr = cmd.rd_idx[AW-1:0];

  assign ti_ext = (INDEX_W+2)'(in_tap_index);
  assign ti_ok  = ti_ext < (INDEX_W+2)'(TAPS);

  assign dl_we      = cmd.shift_we || cmd.clr_we;
  assign dl_wr_addr = cmd.shift_we ? hp_dec : clr_phys;
  assign dl_wr_data = (cmd.shift_we && !cmd.shift_zero) ? in_value : '0;

  always_ff @(posedge clk) begin
    if (cmd.coef_we && ti_ok) begin
      coef_mem[ti_ext[AW-1:0]] <= in_value;
    end
    if (dl_we) begin
      dl_mem[dl_wr_addr] <= dl_wr_data;
    end
    coef_rd_r <= coef_mem[coef_rd_addr];
    dl_rd_r   <= dl_mem[rd_phys];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_vld_r <= '0;
      dl_vld_r   <= '0;
      hp_r       <= '0;
      coef_rv_r  <= 1'b0;
      dl_rv_r    <= 1'b0;
      rd_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      if (cmd.coef_we && ti_ok) begin
        coef_vld_r[ti_ext[AW-1:0]] <= 1'b1;
      end
      if (dl_we) begin
        dl_vld_r[dl_wr_addr] <= 1'b1;
      end
      hp_r       <= hp_nxt;
      coef_rv_r  <= coef_vld_r[coef_rd_addr];
      dl_rv_r    <= dl_vld_r[rd_phys];
      rd_vld_r   <= cmd.rd_en;
      prod_vld_r <= rd_vld_r;
    end
  end

  assign coef_op = coef_rv_r ? coef_rd_r : '0;
  assign dl_op   = dl_rv_r ? dl_rd_r : '0;

  always_ff @(posedge clk) begin
    prod_r <= coef_op * dl_op;
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign rnd = acc_r + ACC_W'(1 << (FRAC_W - 1));
  assign y   = rnd[ACC_W-1:FRAC_W];

  always_comb begin
    sat_flag = 1'b0;
    sat_val  = y[SAMPLE_W-1:0];
    if (y > (ACC_W-FRAC_W)'(32767)) begin
      sat_flag = 1'b1;
      sat_val  = 16'sh7FFF;
    end else if (y < -(ACC_W-FRAC_W)'(32768)) begin
      sat_flag = 1'b1;
      sat_val  = -16'sh8000;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_sample_r    <= sat_val;
      out_clipped_r   <= sat_flag;
      out_block_end_r <= cmd.out_last;
    end
  end

  assign out_sample    = out_sample_r;
  assign out_clipped   = out_clipped_r;
  assign out_block_end = out_block_end_r;

endmodule

### hw/rtl/linear_convolution_fir.sv
// A load beat writes a coefficient. For a sample beat with L active taps, and for
// each zero-shifted tail result after a final one, one shared multiply-accumulate
// walks the taps, one tap per cycle, reading both tap memories through one port
// each; no beat is taken until the result is registered for the output.
// Reset clears the control state, the tap count to 32 and the memory valid bits;
// memories then read as zero until written, with no clearing pass.
module linear_convolution_fir
  import lcf_pkg::*;
#(
  parameter int TAPS = TAPS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  lcf_in_if.sink           in_chan,
  lcf_out_if.source        out_chan,
  lcf_cfg_if.sink          cfg_chan
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_chan.ready = 1'b1;

  lcf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_opcode (in_chan.opcode),
    .in_final  (in_chan.final_sample),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  lcf_datapath #(
    .TAPS (TAPS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_chan.valid),
    .cfg_data      (cfg_chan.data),
    .in_tap_index  (in_chan.tap_index),
    .in_value      (in_chan.value),
    .out_sample    (out_chan.out_sample),
    .out_clipped   (out_chan.clipped),
    .out_block_end (out_chan.block_end)
  );

endmodule

### hw/rtl/lcf_checker.sv
module lcf_checker
  import lcf_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_opcode,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] out_sample,
  input logic                       out_block_end
);

  logic in_beat;

  assign in_beat = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result beat dropped while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_sample) && $stable(out_block_end))
    else $error("Result payload changed while stalled.");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && (in_opcode == OP_LOAD) |=> !$rose(out_valid))
    else $error("Coefficient load produced a result.");

  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && (in_opcode == OP_SAMPLE) |=> !in_ready)
    else $error("Input accepted while a sample is in progress.");

endmodule

bind linear_convolution_fir lcf_checker u_lcf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .in_opcode     (in_chan.opcode),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_sample    (out_chan.out_sample),
  .out_block_end (out_chan.block_end)
);

### tb/linear_convolution_fir_check.sv
module linear_convolution_fir_check
  import lcf_pkg::*;
#(
  parameter int TAPS = TAPS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  lcf_in_if    in_chan,
  lcf_out_if   out_chan,
  lcf_cfg_if   cfg_chan,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint Q15_HI   = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint Q15_LO   = -(longint'(1) << (SAMPLE_W - 1));
  localparam longint HALF_LSB = longint'(1) << (FRAC_W - 1);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       clipped;
    logic                       block_end;
  } conv_result_t;

  logic signed [SAMPLE_W-1:0] history [TAPS];
  logic signed [SAMPLE_W-1:0] coefs [TAPS];
  logic [CNT_W-1:0]           tap_count;
  conv_result_t               expected_results [$];
  int                         errors = 0;
  int                         result_no = 0;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic int active_taps();
    int n;
    n = int'(tap_count);
    if (n == 0) n = 1;
    if (n > TAPS) n = TAPS;
    if (n > RESULT_CAP) n = RESULT_CAP;
    return n;
  endfunction

  function automatic void shift_history(logic signed [SAMPLE_W-1:0] s);
    for (int k = TAPS - 1; k > 0; k--) history[k] = history[k - 1];
    history[0] = s;
  endfunction

  function automatic conv_result_t mac_output(int n, logic last);
    longint       acc;
    longint       y;
    conv_result_t r;
    acc = 0;
    for (int k = 0; k < n; k++) acc += longint'(coefs[k]) * longint'(history[k]);
    y = (acc + HALF_LSB) >>> FRAC_W;
    r.clipped = 1'b0;
    if (y > Q15_HI) begin
      y = Q15_HI;
      r.clipped = 1'b1;
    end else if (y < Q15_LO) begin
      y = Q15_LO;
      r.clipped = 1'b1;
    end
    r.out_sample = y[SAMPLE_W-1:0];
    r.block_end = last;
    return r;
  endfunction

  task automatic convolve_item(op_t op, logic [INDEX_W-1:0] idx,
                               logic signed [SAMPLE_W-1:0] val, logic fin);
    int n;
    if (op == OP_LOAD) begin
      if (int'(idx) < TAPS) coefs[idx] = val;
      return;
    end
    n = active_taps();
    shift_history(val);
    expected_results.push_back(mac_output(n, fin && n == 1));
    if (fin) begin
      for (int t = 1; t < n; t++) begin
        shift_history('0);
        expected_results.push_back(mac_output(n, t == n - 1));
      end
      for (int t = 0; t < n; t++) history[t] = '0;
    end
  endtask

  always @(posedge clk) begin : watch
    conv_result_t want;
    if (!rst_n) begin
      for (int k = 0; k < TAPS; k++) begin
        history[k] = '0;
        coefs[k] = '0;
      end
      tap_count = TAP_COUNT_RST;
      expected_results.delete();
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) tap_count = cfg_chan.data;
      if (in_chan.valid && in_chan.ready) begin
        convolve_item(op_t'(in_chan.opcode), in_chan.tap_index, in_chan.value,
                      in_chan.final_sample);
      end
      if (out_chan.valid && out_chan.ready) begin
        if (expected_results.size() == 0) begin
          if (errors < 10) begin
            $display("%0t: result %0d with none expected: out_sample=%0d clipped=%0b block_end=%0b",
                     $time, result_no, $signed(out_chan.out_sample), out_chan.clipped,
                     out_chan.block_end);
          end
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_chan.out_sample !== want.out_sample || out_chan.clipped !== want.clipped ||
              out_chan.block_end !== want.block_end) begin
            if (errors < 10) begin
              $display("%0t: result %0d expected out_sample=%0d clipped=%0b block_end=%0b",
                       $time, result_no, $signed(want.out_sample), want.clipped,
                       want.block_end);
              $display("%0t: result %0d got      out_sample=%0d clipped=%0b block_end=%0b",
                       $time, result_no, $signed(out_chan.out_sample), out_chan.clipped,
                       out_chan.block_end);
            end
            errors++;
          end
        end
        result_no++;
      end
    end
    pending <= expected_results.size();
    fail_count <= errors;
  end

endmodule

### tb/linear_convolution_fir_tb.sv
module linear_convolution_fir_tb
  import lcf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAPS          = TAPS_DEF;
  localparam int RANDOM_ITEMS  = 200;
  localparam int SETTLE_CYCLES = RESULT_CAP + 32;
  localparam int HOLD_CYCLES   = 500;

  localparam logic signed [SAMPLE_W-1:0] Q15_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] Q15_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  bit   quiet = 1'b0;
  bit   hold_off_req = 1'b0;
  int   active = TAPS;

  lcf_in_if  in_chan ();
  lcf_out_if out_chan ();
  lcf_cfg_if cfg_chan ();

  linear_convolution_fir #(
    .TAPS (TAPS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  linear_convolution_fir_check #(
    .TAPS (TAPS)
  ) conv_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cfg_chan   (cfg_chan),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [SAMPLE_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return Q15_MAX;
      1: return Q15_MIN;
      2: return '0;
      3: return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_item(op_t op, logic [INDEX_W-1:0] idx,
                           logic signed [SAMPLE_W-1:0] val, logic fin);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.opcode <= op;
    in_chan.tap_index <= idx;
    in_chan.value <= val;
    in_chan.final_sample <= fin;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_taps(logic [CNT_W-1:0] taps);
    drain();
    cfg_chan.valid <= 1'b1;
    cfg_chan.data <= taps;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    cfg_chan.valid <= 1'b0;
    active = (taps == 0) ? 1 : ((int'(taps) > TAPS) ? TAPS : int'(taps));
    if (active > RESULT_CAP) active = RESULT_CAP;
  endtask

  initial begin : result_sink
    out_chan.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int sent;
    int seg;
    int n_loads;
    int n_samples;
    bit broken;
    logic [INDEX_W-1:0] idx;
    in_chan.valid <= 1'b0;
    in_chan.opcode <= OP_LOAD;
    in_chan.tap_index <= '0;
    in_chan.value <= '0;
    in_chan.final_sample <= 1'b0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full reset tap count; saturation both ways and a full tail.
    send_item(OP_LOAD, 5'd0, Q15_MIN, 1'b0);
    send_item(OP_LOAD, 5'd1, Q15_MIN, 1'b0);
    send_item(OP_LOAD, 5'd2, 16'sd1, 1'b1);
    send_item(OP_LOAD, 5'd31, Q15_MAX, 1'b0);
    send_item(OP_SAMPLE, 5'd0, Q15_MIN, 1'b0);
    send_item(OP_SAMPLE, 5'd31, Q15_MAX, 1'b0);
    send_item(OP_SAMPLE, 5'd0, Q15_MAX, 1'b0);
    send_item(OP_SAMPLE, 5'd0, Q15_MIN, 1'b1);
    // A single tap ends the block on the sample output itself.
    set_taps(1);
    send_item(OP_SAMPLE, 5'd0, 16'sd16384, 1'b1);
    send_item(OP_SAMPLE, 5'd0, -16'sd1, 1'b0);
    set_taps(0);
    send_item(OP_SAMPLE, 5'd0, Q15_MAX, 1'b1);
    set_taps(63);
    send_item(OP_SAMPLE, 5'd0, 16'sd1, 1'b1);
    // Half an LSB rounds up.
    set_taps(2);
    send_item(OP_LOAD, 5'd0, 16'sd16384, 1'b0);
    send_item(OP_LOAD, 5'd1, 16'sd1, 1'b0);
    send_item(OP_SAMPLE, 5'd0, 16'sd1, 1'b0);
    send_item(OP_SAMPLE, 5'd0, -16'sd1, 1'b1);

    sent = 0;
    seg = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= RANDOM_ITEMS - 40) quiet = 1'b1;
      if (seg == 2) begin
        // The sink holds off while a long signal keeps coming, so the block backs up.
        set_taps(3);
        hold_off_req = 1'b1;
        for (int i = 0; i < 30; i++) begin
          send_item(OP_SAMPLE, INDEX_W'($urandom), pick_value(), i == 29);
          sent++;
        end
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          case ($urandom_range(0, 7))
            0: set_taps(1);
            1: set_taps(32);
            2: set_taps(63);
            3: set_taps(0);
            4: set_taps(CNT_W'($urandom));
            default: set_taps(CNT_W'($urandom_range(2, 8)));
          endcase
        end else if ($urandom_range(0, 4) == 0) begin
          drain();
        end
        n_loads = $urandom_range(0, active);
        for (int i = 0; i < n_loads; i++) begin
          idx = ($urandom_range(0, 3) == 0) ? INDEX_W'($urandom)
                                            : INDEX_W'($urandom_range(0, active - 1));
          send_item(OP_LOAD, idx, pick_value(), 1'($urandom));
          sent++;
        end
        n_samples = $urandom_range(1, 12);
        broken = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < n_samples; i++) begin
          if ($urandom_range(0, 9) == 0) begin
            send_item(OP_LOAD, INDEX_W'($urandom), pick_value(), 1'($urandom));
            sent++;
          end
          send_item(OP_SAMPLE, INDEX_W'($urandom), pick_value(),
                    (i == n_samples - 1) && !broken);
          sent++;
        end
      end
      seg++;
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("** linear_convolution_fir: PASSED **");
    end else begin
      $display("** linear_convolution_fir: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("** linear_convolution_fir: FAILED **");
    $finish;
  end

endmodule
